### hdl/lznt_pkg.sv
// ----------------------------------------------------------------------------
// lznt_pkg
// Shared types and constants for the nibble-token lz block decompressor.
// ----------------------------------------------------------------------------
package lznt_pkg;

   localparam int LANE_MAX = 8;
   localparam int HISTORY_BYTES_DEF = 65536;
   localparam int LANE_BYTES_DEF = 8;
   localparam logic [23:0] MAX_SIZE_RESET = 24'd65536;
   localparam int CMD_DEPTH = 2;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_SIZE = 2'd1,
      ST_OFFSET = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_LIT = 2'd1,
      CMD_MATCH = 2'd2,
      CMD_STAT = 2'd3
   } cmd_kind_type;

   // work command from the parser to the copy engine
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0] data;
      logic [8:0] len;
      logic [15:0] off;
      logic done;
      status_type status;
      logic [23:0] size;
   } cmd_type;

   // one decoded result item
   typedef struct packed {
      logic [LANE_MAX-1:0][7:0] lanes;
      logic [3:0] count;
      logic done;
      status_type status;
      logic [23:0] size;
   } rsp_type;

endpackage

### hdl/lz_nibble_token_decompressor.sv
// ----------------------------------------------------------------------------
// lz_nibble_token_decompressor
// Byte-serial lz block decompressor with nibble-packed tokens.
// ----------------------------------------------------------------------------
// Input queue: drive req_in_byte/req_block_start and raise req_push; a byte
// is taken when req_full is low. req_block_start restarts the header parse.
// Result queue: while rsp_empty is low the oldest item is on the rsp_ ports;
// raise rsp_pop to take it. Lanes fill from lane 0, rsp_byte_count valid.
// csr_we with csr_write_data sets the largest allowed decoded size.
// The parser takes one byte per cycle while req_full is low into a two-entry
// command queue. The copy engine writes a literal straight to history and
// the output register, and copies a match byte by byte (history read, then
// write), emitting a chunk whenever the lanes fill or the match ends, so
// long matches stall input once the command queue fills. A literal's result
// passes through the command queue and then the output register; a match's
// first chunk passes the command queue, a read and write per byte, then emit.
// A stalled receiver holds the output register; the engine then waits and
// the command queue backs up to req_full. Reset empties both queues and
// returns the parser to waiting for a header; history contents are kept.
// ----------------------------------------------------------------------------
module lz_nibble_token_decompressor import lznt_pkg::*; #(
   parameter int HISTORY_BYTES = HISTORY_BYTES_DEF,
   parameter int LANE_BYTES = LANE_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [7:0] req_in_byte,
   input  logic req_block_start,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [7:0] rsp_out_byte3,
   output logic [7:0] rsp_out_byte4,
   output logic [7:0] rsp_out_byte5,
   output logic [7:0] rsp_out_byte6,
   output logic [7:0] rsp_out_byte7,
   output logic [3:0] rsp_byte_count,
   output logic rsp_block_done,
   output logic [1:0] rsp_status,
   output logic [23:0] rsp_block_size,
   input  logic csr_we,
   input  logic [23:0] csr_write_data
);
   logic [23:0] max_size_ff;
   logic accept, cmd_push, cmd_pop, cmd_empty, rsp_valid;
   cmd_type cmd_new, cmd_head;
   rsp_type rsp;

   assign accept = req_push && !req_full;
   assign rsp_empty = !rsp_valid;

   // size limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_SIZE_RESET;
      end else if (csr_we) begin
         max_size_ff <= csr_write_data;
      end
   end

   lznt_parser u_parser (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .in_byte(req_in_byte),
      .block_start(req_block_start),
      .max_size(max_size_ff),
      .cmd_push(cmd_push),
      .cmd(cmd_new)
   );

   lznt_cmd_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .push_cmd(cmd_new),
      .full(req_full),
      .pop(cmd_pop),
      .empty(cmd_empty),
      .head(cmd_head)
   );

   lznt_copier #(
      .HISTORY_BYTES(HISTORY_BYTES),
      .LANE_BYTES(LANE_BYTES)
   ) u_copier (
      .clock(clock),
      .reset(reset),
      .cmd_valid(!cmd_empty),
      .cmd(cmd_head),
      .cmd_pop(cmd_pop),
      .rsp_valid(rsp_valid),
      .rsp_pop(rsp_pop),
      .rsp(rsp)
   );

   // result fields
   assign rsp_out_byte0 = rsp.lanes[0];
   assign rsp_out_byte1 = rsp.lanes[1];
   assign rsp_out_byte2 = rsp.lanes[2];
   assign rsp_out_byte3 = rsp.lanes[3];
   assign rsp_out_byte4 = rsp.lanes[4];
   assign rsp_out_byte5 = rsp.lanes[5];
   assign rsp_out_byte6 = rsp.lanes[6];
   assign rsp_out_byte7 = rsp.lanes[7];
   assign rsp_byte_count = rsp.count;
   assign rsp_block_done = rsp.done;
   assign rsp_status = rsp.status;
   assign rsp_block_size = rsp.size;
endmodule

### hdl/lznt_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lznt_cmd_fifo
// Short command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lznt_cmd_fifo import lznt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  cmd_type push_cmd,
   output logic full,
   input  logic pop,
   output logic empty,
   output cmd_type head
);
   localparam int PW = $clog2(CMD_DEPTH);

   cmd_type mem_ff [CMD_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == (PW+1)'(CMD_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head = mem_ff[rp_ff];

   // pointer and count update
   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(CMD_DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(CMD_DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_cmd;
      end
   end
endmodule

### hdl/lznt_parser.sv
// ----------------------------------------------------------------------------
// lznt_parser
// Front end: parses header, token nibbles, extensions and offsets into
// commands for the copy engine.
// ----------------------------------------------------------------------------
module lznt_parser import lznt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [7:0] in_byte,
   input  logic block_start,
   input  logic [23:0] max_size,
   output logic cmd_push,
   output cmd_type cmd
);
   typedef enum logic [11:0] {
      PH_IDLE = 12'b000000000001,
      PH_SZ1 = 12'b000000000010,
      PH_SZ2 = 12'b000000000100,
      PH_CN0 = 12'b000000001000,
      PH_CN1 = 12'b000000010000,
      PH_CN2 = 12'b000000100000,
      PH_TOKEN = 12'b000001000000,
      PH_EXT_LIT = 12'b000010000000,
      PH_EXT_MATCH = 12'b000100000000,
      PH_LIT = 12'b001000000000,
      PH_OFF_LO = 12'b010000000000,
      PH_OFF_HI = 12'b100000000000
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic [8:0] len;
   } tok_type;

   function automatic tok_type start_tok(input logic [3:0] nib);
      tok_type t;
      if (nib[3]) begin
         t.len = 9'(nib[2:0]) + 9'd1;
         t.phase = (nib[2:0] == 3'd7) ? PH_EXT_LIT : PH_LIT;
      end else begin
         t.len = 9'(nib[2:0]) + 9'd4;
         t.phase = (nib[2:0] == 3'd7) ? PH_EXT_MATCH : PH_OFF_LO;
      end
      return t;
   endfunction

   phase_type phase_ff, phase_in;
   logic [23:0] size_ff, size_in;
   logic [23:0] tok_ff, tok_in;
   logic [3:0] held_ff, held_in;
   logic nheld_ff, nheld_in;
   logic [8:0] len_ff, len_in;
   logic [8:0] lit_ff, lit_in;
   logic [7:0] offlo_ff, offlo_in;

   tok_type st_hi, st_held;
   logic [23:0] tok_dec;
   logic [8:0] lit_dec;
   logic [8:0] ext_len;
   logic last_tok;

   assign st_hi = start_tok(in_byte[7:4]);
   assign st_held = start_tok(held_ff);
   assign tok_dec = tok_ff - 24'd1;
   assign lit_dec = lit_ff - 9'd1;
   assign ext_len = len_ff + 9'(in_byte);
   assign last_tok = (tok_dec == '0);

   // parse step for one accepted byte
   always_comb begin
      phase_in = phase_ff;
      size_in = size_ff;
      tok_in = tok_ff;
      held_in = held_ff;
      nheld_in = nheld_ff;
      len_in = len_ff;
      lit_in = lit_ff;
      offlo_in = offlo_ff;
      cmd_push = 1'b0;
      cmd = '0;
      cmd.size = size_ff;
      if (accept) begin
         if (block_start) begin
            size_in = 24'(in_byte);
            tok_in = '0;
            held_in = '0;
            nheld_in = 1'b0;
            len_in = '0;
            lit_in = '0;
            offlo_in = '0;
            phase_in = PH_SZ1;
            cmd_push = 1'b1;
            cmd.kind = CMD_START;
         end else begin
            unique case (phase_ff)
               PH_SZ1: begin
                  size_in = size_ff | {8'd0, in_byte, 8'd0};
                  phase_in = PH_SZ2;
               end
               PH_SZ2: begin
                  size_in = size_ff | {in_byte, 16'd0};
                  if (size_in > max_size) begin
                     phase_in = PH_IDLE;
                     cmd_push = 1'b1;
                     cmd.kind = CMD_STAT;
                     cmd.done = 1'b1;
                     cmd.status = ST_SIZE;
                     cmd.size = '0;
                  end else begin
                     phase_in = PH_CN0;
                  end
               end
               PH_CN0: begin
                  tok_in = 24'(in_byte);
                  phase_in = PH_CN1;
               end
               PH_CN1: begin
                  tok_in = tok_ff | {8'd0, in_byte, 8'd0};
                  phase_in = PH_CN2;
               end
               PH_CN2: begin
                  tok_in = tok_ff | {in_byte, 16'd0};
                  if (tok_in == '0) begin
                     phase_in = PH_IDLE;
                     cmd_push = 1'b1;
                     cmd.kind = CMD_STAT;
                     cmd.done = 1'b1;
                     cmd.status = ST_OK;
                  end else begin
                     phase_in = PH_TOKEN;
                  end
               end
               PH_TOKEN: begin
                  held_in = in_byte[3:0];
                  nheld_in = 1'b1;
                  phase_in = st_hi.phase;
                  len_in = st_hi.len;
                  lit_in = st_hi.len;
               end
               PH_EXT_LIT, PH_EXT_MATCH: begin
                  len_in = ext_len;
                  lit_in = ext_len;
                  phase_in = (phase_ff == PH_EXT_LIT) ? PH_LIT : PH_OFF_LO;
               end
               PH_OFF_LO: begin
                  offlo_in = in_byte;
                  phase_in = PH_OFF_HI;
               end
               PH_LIT, PH_OFF_HI: begin
                  cmd_push = 1'b1;
                  cmd.data = in_byte;
                  cmd.len = len_ff;
                  cmd.off = {in_byte, offlo_ff};
                  cmd.kind = (phase_ff == PH_LIT) ? CMD_LIT : CMD_MATCH;
                  if (phase_ff == PH_LIT) begin
                     lit_in = lit_dec;
                  end
                  // token ends: after the last literal byte or on the offset
                  if (phase_ff == PH_OFF_HI || lit_dec == '0) begin
                     tok_in = tok_dec;
                     if (last_tok) begin
                        phase_in = PH_IDLE;
                        nheld_in = 1'b0;
                        cmd.done = 1'b1;
                     end else if (nheld_ff) begin
                        nheld_in = 1'b0;
                        phase_in = st_held.phase;
                        len_in = st_held.len;
                        lit_in = st_held.len;
                     end else begin
                        phase_in = PH_TOKEN;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         size_ff <= '0;
         tok_ff <= '0;
         held_ff <= '0;
         nheld_ff <= 1'b0;
         len_ff <= '0;
         lit_ff <= '0;
         offlo_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         size_ff <= size_in;
         tok_ff <= tok_in;
         held_ff <= held_in;
         nheld_ff <= nheld_in;
         len_ff <= len_in;
         lit_ff <= lit_in;
         offlo_ff <= offlo_in;
      end
   end
endmodule

### hdl/lznt_copier.sv
// ----------------------------------------------------------------------------
// lznt_copier
// Back end: writes literals to the history memory, copies matches byte by
// byte, packs bytes into lane chunks and holds the output register.
// ----------------------------------------------------------------------------
module lznt_copier import lznt_pkg::*; #(
   parameter int HISTORY_BYTES = HISTORY_BYTES_DEF,
   parameter int LANE_BYTES = LANE_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   input  cmd_type cmd,
   output logic cmd_pop,
   output logic rsp_valid,
   input  logic rsp_pop,
   output rsp_type rsp
);
   localparam int AW = $clog2(HISTORY_BYTES);

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_READ = 4'b0010,
      B_WRITE = 4'b0100,
      B_EMIT = 4'b1000
   } bstate_type;

   logic [7:0] mem [HISTORY_BYTES];
   logic [7:0] rdata_ff;

   bstate_type st_ff, st_in;
   logic [AW-1:0] wr_ff, wr_in, src_ff, src_in;
   logic [23:0] pos_ff, pos_in;
   logic drop_ff, drop_in;
   logic [8:0] left_ff, left_in;
   logic [LANE_MAX-1:0][7:0] lane_ff, lane_in;
   logic [3:0] cnt_ff, cnt_in;
   logic mdone_ff, mdone_in;
   logic [23:0] msize_ff, msize_in;
   logic ov_ff, ov_in;
   rsp_type ro_ff, ro_in;

   logic out_free, we;
   logic [7:0] wdata;
   logic [AW-1:0] wr_next, src_next;
   logic [23:0] pos_next;
   logic bad_off;
   logic [17:0] back_sum;

   assign out_free = !ov_ff || rsp_pop;
   assign rsp_valid = ov_ff;
   assign rsp = ro_ff;
   assign wr_next = (wr_ff == AW'(HISTORY_BYTES-1)) ? '0 : wr_ff + 1'b1;
   assign src_next = (src_ff == AW'(HISTORY_BYTES-1)) ? '0 : src_ff + 1'b1;
   assign pos_next = (pos_ff == 24'hFFFFFF) ? pos_ff : pos_ff + 24'd1;
   assign bad_off = (cmd.off == '0) || ({1'b0, cmd.off} > 17'(HISTORY_BYTES))
      || (24'(cmd.off) > pos_ff);
   assign back_sum = 18'(wr_ff) + 18'(HISTORY_BYTES) - 18'(cmd.off);

   // command execution
   always_comb begin
      st_in = st_ff;
      wr_in = wr_ff;
      src_in = src_ff;
      pos_in = pos_ff;
      drop_in = drop_ff;
      left_in = left_ff;
      lane_in = lane_ff;
      cnt_in = cnt_ff;
      mdone_in = mdone_ff;
      msize_in = msize_ff;
      ov_in = ov_ff && !rsp_pop;
      ro_in = ro_ff;
      cmd_pop = 1'b0;
      we = 1'b0;
      wdata = cmd.data;
      unique case (st_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == CMD_START) begin
                  cmd_pop = 1'b1;
                  wr_in = '0;
                  pos_in = '0;
                  drop_in = 1'b0;
               end else if (drop_ff) begin
                  cmd_pop = 1'b1;
               end else if (out_free) begin
                  cmd_pop = 1'b1;
                  ro_in = '0;
                  ro_in.size = cmd.done ? cmd.size : '0;
                  ro_in.done = cmd.done;
                  case (cmd.kind)
                     CMD_LIT: begin
                        ov_in = 1'b1;
                        we = 1'b1;
                        wr_in = wr_next;
                        pos_in = pos_next;
                        ro_in.lanes[0] = cmd.data;
                        ro_in.count = 4'd1;
                     end
                     CMD_MATCH: begin
                        if (bad_off) begin
                           ov_in = 1'b1;
                           drop_in = 1'b1;
                           ro_in.done = 1'b1;
                           ro_in.size = cmd.size;
                           ro_in.status = ST_OFFSET;
                        end else begin
                           src_in = (back_sum >= 18'(HISTORY_BYTES))
                              ? AW'(back_sum - 18'(HISTORY_BYTES)) : AW'(back_sum);
                           left_in = cmd.len;
                           lane_in = '0;
                           cnt_in = '0;
                           mdone_in = cmd.done;
                           msize_in = cmd.size;
                           st_in = B_READ;
                        end
                     end
                     default: begin
                        ov_in = 1'b1;
                        ro_in.status = cmd.status;
                     end
                  endcase
               end
            end
         end
         B_READ: begin
            src_in = src_next;
            st_in = B_WRITE;
         end
         B_WRITE: begin
            we = 1'b1;
            wdata = rdata_ff;
            wr_in = wr_next;
            pos_in = pos_next;
            lane_in[cnt_ff[2:0]] = rdata_ff;
            cnt_in = cnt_ff + 4'd1;
            left_in = left_ff - 9'd1;
            st_in = (left_in == '0 || cnt_in == 4'(LANE_BYTES)) ? B_EMIT : B_READ;
         end
         B_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1;
               ro_in.lanes = lane_ff;
               ro_in.count = cnt_ff;
               ro_in.status = ST_OK;
               ro_in.done = (left_ff == '0) && mdone_ff;
               ro_in.size = ro_in.done ? msize_ff : '0;
               lane_in = '0;
               cnt_in = '0;
               st_in = (left_ff == '0) ? B_IDLE : B_READ;
            end
         end
         default: begin
            st_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= B_IDLE;
         wr_ff <= '0;
         pos_ff <= '0;
         drop_ff <= 1'b0;
         ov_ff <= 1'b0;
         cnt_ff <= '0;
         left_ff <= '0;
      end else begin
         st_ff <= st_in;
         wr_ff <= wr_in;
         pos_ff <= pos_in;
         drop_ff <= drop_in;
         ov_ff <= ov_in;
         cnt_ff <= cnt_in;
         left_ff <= left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff <= src_in;
      lane_ff <= lane_in;
      mdone_ff <= mdone_in;
      msize_ff <= msize_in;
      ro_ff <= ro_in;
   end

   // history memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == B_READ) begin
         rdata_ff <= mem[src_ff];
      end
   end
endmodule

### sim/tb_lz_nibble_token_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz_nibble_token_decompressor
// Self-checking bench for the nibble-token lz block decompressor. Compressed
// blocks are built on the fly (headers, literal and match tokens, extension
// bytes, bad offsets, oversize headers, restarts, stray bytes) and fed through
// the input queue. A software copy of the decoder predicts every result item,
// which the monitor compares field by field. Several size limits are used.
// ----------------------------------------------------------------------------
module tb_lz_nibble_token_decompressor;
   import lznt_pkg::*;

   localparam int HIST = 65536;
   localparam int LANES = 8;
   localparam int STALL_LIMIT = 20000;

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0, PH_SIZE1 = 4'd1, PH_SIZE2 = 4'd2, PH_CNT0 = 4'd3,
      PH_CNT1 = 4'd4, PH_CNT2 = 4'd5, PH_TOKEN = 4'd6, PH_EXT_LIT = 4'd7,
      PH_EXT_MATCH = 4'd8, PH_LIT = 4'd9, PH_OFF_LO = 4'd10, PH_OFF_HI = 4'd11
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic start;
   } stream_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [7:0] req_in_byte = '0;
   logic req_block_start = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte0, rsp_out_byte1, rsp_out_byte2, rsp_out_byte3;
   logic [7:0] rsp_out_byte4, rsp_out_byte5, rsp_out_byte6, rsp_out_byte7;
   logic [3:0] rsp_byte_count;
   logic rsp_block_done;
   logic [1:0] rsp_status;
   logic [23:0] rsp_block_size;
   logic csr_we = 1'b0;
   logic [23:0] csr_write_data = '0;

   lz_nibble_token_decompressor u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_in_byte(req_in_byte), .req_block_start(req_block_start),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_byte0(rsp_out_byte0), .rsp_out_byte1(rsp_out_byte1),
      .rsp_out_byte2(rsp_out_byte2), .rsp_out_byte3(rsp_out_byte3),
      .rsp_out_byte4(rsp_out_byte4), .rsp_out_byte5(rsp_out_byte5),
      .rsp_out_byte6(rsp_out_byte6), .rsp_out_byte7(rsp_out_byte7),
      .rsp_byte_count(rsp_byte_count), .rsp_block_done(rsp_block_done),
      .rsp_status(rsp_status), .rsp_block_size(rsp_block_size),
      .csr_we(csr_we), .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   stream_item_type pending_bytes[$];
   rsp_type decoded_chunks[$];
   int errors = 0;
   int chunks_checked = 0;
   int blocks_sent = 0;
   int stall_cycles = 0;
   int send_idle_pct = 10;
   int take_idle_pct = 67;

   // decoder copy
   logic [23:0] size_limit;
   phase_type dec_phase;
   logic [23:0] dec_size, dec_tokens, dec_pos;
   logic [3:0] dec_held;
   logic dec_has_held;
   logic [8:0] dec_len, dec_lit_left;
   logic [7:0] dec_off_lo;
   logic [15:0] dec_wr;
   logic [7:0] dec_hist [0:HIST-1];

   function automatic void emit_chunk(logic [7:0] bytes [LANES], int n, logic done,
                                      status_type st, logic [23:0] size);
      rsp_type r;
      r = '0;
      for (int i = 0; i < LANES; i++) r.lanes[i] = (i < n) ? bytes[i] : 8'h00;
      r.count = n[3:0];
      r.done = done;
      r.status = st;
      r.size = done ? size : 24'h0;
      decoded_chunks.push_back(r);
   endfunction

   function automatic void hist_write(logic [7:0] b);
      dec_hist[dec_wr] = b;
      dec_wr = dec_wr + 16'd1;
      if (dec_pos != 24'hFFFFFF) dec_pos = dec_pos + 24'd1;
   endfunction

   function automatic void begin_token(logic [3:0] nib);
      if (nib[3]) begin
         dec_len = {6'd0, nib[2:0]} + 9'd1;
         dec_phase = (nib[2:0] == 3'd7) ? PH_EXT_LIT : PH_LIT;
      end else begin
         dec_len = {6'd0, nib[2:0]} + 9'd4;
         dec_phase = (nib[2:0] == 3'd7) ? PH_EXT_MATCH : PH_OFF_LO;
      end
      dec_lit_left = dec_len;
   endfunction

   // retire one token, returns 1 when the block is complete
   function automatic logic finish_token();
      dec_tokens = dec_tokens - 24'd1;
      if (dec_tokens == 24'd0) begin
         dec_phase = PH_IDLE;
         dec_has_held = 1'b0;
         return 1'b1;
      end
      if (dec_has_held) begin
         dec_has_held = 1'b0;
         begin_token(dec_held);
      end else begin
         dec_phase = PH_TOKEN;
      end
      return 1'b0;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic start);
      logic [7:0] lane [LANES];
      logic [16:0] off;
      logic [15:0] src;
      int left, n;
      logic done;
      foreach (lane[i]) lane[i] = 8'h00;
      if (start) begin
         dec_size = {16'd0, b};
         dec_tokens = '0;
         dec_held = '0;
         dec_has_held = 1'b0;
         dec_len = '0;
         dec_lit_left = '0;
         dec_off_lo = '0;
         dec_pos = '0;
         dec_wr = '0;
         dec_phase = PH_SIZE1;
         return;
      end
      case (dec_phase)
         PH_SIZE1: begin
            dec_size[15:8] = b;
            dec_phase = PH_SIZE2;
         end
         PH_SIZE2: begin
            dec_size[23:16] = b;
            if (dec_size > size_limit) begin
               dec_phase = PH_IDLE;
               emit_chunk(lane, 0, 1'b1, ST_SIZE, 24'h0);
            end else begin
               dec_phase = PH_CNT0;
            end
         end
         PH_CNT0: begin
            dec_tokens = {16'd0, b};
            dec_phase = PH_CNT1;
         end
         PH_CNT1: begin
            dec_tokens[15:8] = b;
            dec_phase = PH_CNT2;
         end
         PH_CNT2: begin
            dec_tokens[23:16] = b;
            if (dec_tokens == 24'd0) begin
               dec_phase = PH_IDLE;
               emit_chunk(lane, 0, 1'b1, ST_OK, dec_size);
            end else begin
               dec_phase = PH_TOKEN;
            end
         end
         PH_TOKEN: begin
            dec_held = b[3:0];
            dec_has_held = 1'b1;
            begin_token(b[7:4]);
         end
         PH_EXT_LIT, PH_EXT_MATCH: begin
            dec_len = dec_len + {1'b0, b};
            dec_lit_left = dec_len;
            dec_phase = (dec_phase == PH_EXT_LIT) ? PH_LIT : PH_OFF_LO;
         end
         PH_LIT: begin
            done = 1'b0;
            lane[0] = b;
            hist_write(b);
            dec_lit_left = dec_lit_left - 9'd1;
            if (dec_lit_left == 9'd0) done = finish_token();
            emit_chunk(lane, 1, done, ST_OK, dec_size);
         end
         PH_OFF_LO: begin
            dec_off_lo = b;
            dec_phase = PH_OFF_HI;
         end
         PH_OFF_HI: begin
            off = {1'b0, b, dec_off_lo};
            if (off == 17'd0 || off > 17'(HIST) || {7'd0, off} > dec_pos) begin
               dec_phase = PH_IDLE;
               dec_has_held = 1'b0;
               emit_chunk(lane, 0, 1'b1, ST_OFFSET, dec_size);
            end else begin
               src = dec_wr - off[15:0];
               left = dec_len;
               done = finish_token();
               while (left > 0) begin
                  n = 0;
                  while (n < LANES && left > 0) begin
                     lane[n] = dec_hist[src];
                     hist_write(dec_hist[src]);
                     src = src + 16'd1;
                     n++;
                     left--;
                  end
                  emit_chunk(lane, n, (left == 0) ? done : 1'b0, ST_OK, dec_size);
               end
            end
         end
         default: dec_phase = PH_IDLE;
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch on item %0d: %s got %0h expected %0h",
               chunks_checked, what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      logic send;
      if (req_push && !req_full) begin
         decode_byte(pending_bytes[0].data, pending_bytes[0].start);
         void'(pending_bytes.pop_front());
      end
      send = !reset && pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct;
      req_push <= send;
      if (send) begin
         req_in_byte <= pending_bytes[0].data;
         req_block_start <= pending_bytes[0].start;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type w;
      logic [7:0] got [LANES];
      if (rsp_pop && !rsp_empty) begin
         got = '{rsp_out_byte0, rsp_out_byte1, rsp_out_byte2, rsp_out_byte3,
                 rsp_out_byte4, rsp_out_byte5, rsp_out_byte6, rsp_out_byte7};
         if (decoded_chunks.size() == 0) begin
            report_mismatch("unexpected item", rsp_byte_count, 0);
         end else begin
            w = decoded_chunks.pop_front();
            for (int i = 0; i < LANES; i++)
               if (got[i] !== w.lanes[i]) report_mismatch($sformatf("lane %0d", i),
                                                          got[i], w.lanes[i]);
            if (rsp_byte_count !== w.count)
               report_mismatch("byte_count", rsp_byte_count, w.count);
            if (rsp_block_done !== w.done)
               report_mismatch("block_done", rsp_block_done, w.done);
            if (rsp_status !== w.status) report_mismatch("status", rsp_status, w.status);
            if (rsp_block_size !== w.size)
               report_mismatch("block_size", rsp_block_size, w.size);
         end
         chunks_checked++;
      end
      rsp_pop <= !reset && $urandom_range(0, 99) >= take_idle_pct;
   end

   // watchdog on cycles without progress while work is outstanding
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (pending_bytes.size() == 0 && decoded_chunks.size() == 0)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_byte(logic [7:0] b, logic s = 1'b0);
      pending_bytes.push_back('{data: b, start: s});
   endtask

   task automatic push_header(logic [23:0] size, logic [23:0] count);
      push_byte(size[7:0], 1'b1);
      push_byte(size[15:8]);
      push_byte(size[23:16]);
      if (size > size_limit) return;
      push_byte(count[7:0]);
      push_byte(count[15:8]);
      push_byte(count[23:16]);
   endtask

   // random token body, returns 0 once the block has ended early
   task automatic push_token(logic [3:0] nib, inout int pos, output logic alive);
      int len, off;
      alive = 1'b1;
      len = nib[3] ? nib[2:0] + 1 : nib[2:0] + 4;
      if (nib[2:0] == 3'd7) begin
         off = nib[3] ? $urandom_range(0, 12) :
               ($urandom_range(0, 19) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 24));
         push_byte(off[7:0]);
         len += off;
      end
      if (nib[3]) begin
         repeat (len) push_byte($urandom_range(0, 255));
         pos += len;
      end else if (pos == 0 || $urandom_range(0, 29) == 0) begin
         off = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(pos + 1, 65535);
         push_byte(off[7:0]);
         push_byte(off[15:8]);
         alive = 1'b0;
      end else begin
         off = (pos > 65535) ? 65535 : pos;
         off = $urandom_range(0, 1) ? $urandom_range(1, (off < 8) ? off : 8)
                                    : $urandom_range(1, off);
         push_byte(off[7:0]);
         push_byte(off[15:8]);
         pos += len;
      end
   endtask

   task automatic push_random_block();
      logic [23:0] size, count;
      logic [7:0] tok;
      logic alive;
      int pos;
      pos = 0;
      blocks_sent++;
      case ($urandom_range(0, 9))
         0: size = $urandom_range(0, 24'hFFFFFF);
         1: size = size_limit;
         default: size = $urandom_range(0, 400);
      endcase
      count = ($urandom_range(0, 9) == 0) ? 24'd0 : $urandom_range(1, 7);
      push_header(size, count);
      if (size > size_limit) return;
      for (int t = 0; t < count; t += 2) begin
         if ($urandom_range(0, 39) == 0) return;
         tok = $urandom_range(0, 255);
         push_byte(tok);
         push_token(tok[7:4], pos, alive);
         if (!alive || t + 1 >= count) return;
         push_token(tok[3:0], pos, alive);
         if (!alive) return;
      end
   endtask

   task automatic set_limit(logic [23:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_write_data <= value;
      size_limit = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending_bytes.size() > 0 || decoded_chunks.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_phase(logic [23:0] limit, int items);
      int start_count;
      set_limit(limit);
      start_count = pending_bytes.size();
      while (pending_bytes.size() - start_count < items) begin
         if ($urandom_range(0, 19) == 0) push_byte($urandom_range(0, 255));
         push_random_block();
      end
      drain();
   endtask

   initial begin
      size_limit = MAX_SIZE_RESET;
      dec_phase = PH_IDLE;
      dec_size = '0; dec_tokens = '0; dec_pos = '0; dec_wr = '0;
      dec_held = '0; dec_has_held = 1'b0; dec_len = '0; dec_lit_left = '0;
      dec_off_lo = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: stray byte, oversize, empty block, literals with overlap copy,
      // offsets beyond the output and zero offset
      set_limit(24'd16);
      push_byte(8'hA5);
      push_header(24'd20, 24'd0);
      push_header(24'd16, 24'd0);
      push_header(24'd5, 24'd2);
      push_byte(8'h90); push_byte(8'h00); push_byte(8'hFF);
      push_byte(8'h01); push_byte(8'h00);
      push_header(24'd1, 24'd1);
      push_byte(8'h0F); push_byte(8'h01); push_byte(8'h00);
      push_header(24'd2, 24'd2);
      push_byte(8'h80); push_byte(8'h7E); push_byte(8'h00); push_byte(8'h00);
      drain();

      random_phase(24'hFFFFFF, 80);
      send_idle_pct = 67;
      take_idle_pct = 10;
      random_phase(24'd0, 30);
      random_phase(MAX_SIZE_RESET, 45);
      send_idle_pct = 0;
      take_idle_pct = 0;
      random_phase($urandom_range(0, 24'hFFFFFF), 45);

      $display("checked %0d result items over %0d random blocks", chunks_checked, blocks_sent);
      $display("size limits 16, max, 0, reset value and random; three idle patterns");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
